FILE: rtl/cnr_pkg.sv
// ----------------------------------------------------------------------------
// cnr_pkg
// Shared types, constants and saturating helpers for the cubic Newton
// root finder.
// ----------------------------------------------------------------------------
`default_nettype none

package cnr_pkg;

  localparam int unsigned CNR_DATA_W    = 32;
  localparam int unsigned CNR_FRAC_BITS = 16;
  localparam int unsigned CNR_ADDR_W    = 4;

  // register indexes (byte address / 4)
  localparam logic [1:0] CNR_REG_TOLERANCE   = 2'd0;
  localparam logic [1:0] CNR_REG_ITER_LIMIT  = 2'd1;
  localparam logic [1:0] CNR_REG_SLOPE_FLOOR = 2'd2;

  localparam logic [15:0] CNR_TOLERANCE_RST   = 16'd66;
  localparam logic [7:0]  CNR_ITER_LIMIT_RST  = 8'd50;
  localparam logic [30:0] CNR_SLOPE_FLOOR_RST = 31'd655;

  typedef struct packed {
    logic [15:0] tolerance;
    logic [7:0]  iteration_limit;
    logic [30:0] slope_floor;
  } cnr_cfg_t;

  typedef enum logic [2:0] {
    ALU_MUL,
    ALU_SCALE3,
    ALU_SCALE9,
    ALU_ADD,
    ALU_SUB
  } cnr_alu_op_e;

  typedef enum logic [1:0] {
    STAT_CONVERGED   = 2'd0,
    STAT_LIMIT       = 2'd1,
    STAT_START_SLOPE = 2'd2,
    STAT_ZERO_SLOPE  = 2'd3
  } cnr_status_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_LOOP,
    PH_PREV,
    PH_NEWF
  } cnr_phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L9,
    ST_SX2,
    ST_SQ,
    ST_S3,
    ST_SS,
    ST_SCHK,
    ST_FX3,
    ST_FCUB,
    ST_FLIN,
    ST_F9,
    ST_FSUB,
    ST_FADD,
    ST_FCHK,
    ST_DIV,
    ST_STEP
  } cnr_state_e;

  typedef struct packed {
    logic        valid;
    cnr_status_e status;
  } cnr_fin_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // exact magnitude: -2^31 maps to 2^31 as an unsigned word
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [31:0] u;
    u = v;
    return v[31] ? (32'd0 - u) : u;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cnr_alu.sv
// ----------------------------------------------------------------------------
// cnr_alu
// Shared saturating fixed-point unit: multiply, scale by 3 or 9, add, sub.
// ----------------------------------------------------------------------------
`default_nettype none

module cnr_alu #(
  parameter int unsigned FRAC_BITS = cnr_pkg::CNR_FRAC_BITS
) (
  input  cnr_pkg::cnr_alu_op_e       op_i,
  input  logic signed [31:0]         a_i,
  input  logic signed [31:0]         b_i,
  output logic signed [31:0]         res_o
);
  import cnr_pkg::*;

  logic signed [63:0] a_ext;
  logic signed [63:0] b_ext;
  logic signed [63:0] prod;
  logic signed [63:0] wide;

  assign a_ext = 64'(a_i);
  assign b_ext = 64'(b_i);
  assign prod  = a_ext * b_ext;

  always_comb begin
    case (op_i)
      ALU_MUL:    wide = prod >>> FRAC_BITS;  // floor shift
      ALU_SCALE3: wide = (a_ext <<< 1) + a_ext;
      ALU_SCALE9: wide = (a_ext <<< 3) + a_ext;
      ALU_ADD:    wide = a_ext + b_ext;
      ALU_SUB:    wide = a_ext - b_ext;
      default:    wide = a_ext;
    endcase
  end

  assign res_o = sat32(wide);

endmodule

`default_nettype wire

FILE: rtl/cnr_div.sv
// ----------------------------------------------------------------------------
// cnr_div
// Radix-2 restoring divider: (num * 2^FRAC_BITS) / den, truncated toward
// zero and saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cnr_div #(
  parameter int unsigned FRAC_BITS = cnr_pkg::CNR_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  import cnr_pkg::*;

  localparam int unsigned DIV_W = CNR_DATA_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(DIV_W + 1);
  localparam logic [DIV_W-1:0] MAG_MAX_POS = DIV_W'(32'h7fff_ffff);
  localparam logic [DIV_W-1:0] MAG_MAX_NEG = DIV_W'(32'h8000_0000);

  logic [31:0]      rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [31:0]      den_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(DIV_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= {abs32(num_i), {FRAC_BITS{1'b0}}};
      den_q <= abs32(den_i);
      neg_q <= num_i[31] ^ den_i[31];
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  always_comb begin
    if (neg_q) begin
      quot_o = (quo_q > MAG_MAX_NEG) ? 32'sh80000000 : (32'sd0 - quo_q[31:0]);
    end else begin
      quot_o = (quo_q > MAG_MAX_POS) ? 32'sh7fffffff : quo_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: rtl/cnr_cfg.sv
// ----------------------------------------------------------------------------
// cnr_cfg
// APB register bank: tolerance, iteration limit, slope floor.
// ----------------------------------------------------------------------------
`default_nettype none

module cnr_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cnr_pkg::CNR_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output cnr_pkg::cnr_cfg_t               cfg_o
);
  import cnr_pkg::*;

  cnr_cfg_t   cfg_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CNR_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance       <= CNR_TOLERANCE_RST;
      cfg_q.iteration_limit <= CNR_ITER_LIMIT_RST;
      cfg_q.slope_floor     <= CNR_SLOPE_FLOOR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        CNR_REG_TOLERANCE:   cfg_q.tolerance       <= pwdata[15:0];
        CNR_REG_ITER_LIMIT:  cfg_q.iteration_limit <= pwdata[7:0];
        CNR_REG_SLOPE_FLOOR: cfg_q.slope_floor     <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      CNR_REG_TOLERANCE:   prdata = {16'd0, cfg_q.tolerance};
      CNR_REG_ITER_LIMIT:  prdata = {24'd0, cfg_q.iteration_limit};
      CNR_REG_SLOPE_FLOOR: prdata = {1'b0, cfg_q.slope_floor};
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/cubic_newton_root_finder_core.sv
// ----------------------------------------------------------------------------
// cubic_newton_root_finder_core
// Newton-Raphson root finder for f(x) = a3*x^3 - 9*a2*x + 3 in saturating
// signed fixed point, one shared ALU under a sequencer plus a serial divider.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result. The result appears on root_o, status_o and steps_used_o
// for exactly one cycle with done_o high and cannot be stalled, so the
// receiver must take it in that cycle. Setup computes the start slope and f
// at x0, one ALU operation per cycle. Each Newton step then runs the slope
// and f through the ALU, with a second slope pass at the previous point when
// needed, plus the serial divider, which retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_newton_root_finder_core #(
  parameter int unsigned FRAC_BITS = cnr_pkg::CNR_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              coef_cubic_i,
  input  logic signed [31:0]              coef_linear_i,
  input  logic signed [31:0]              start_point_i,
  output logic                            done_o,
  output logic signed [31:0]              root_o,
  output logic [1:0]                      status_o,
  output logic [7:0]                      steps_used_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cnr_pkg::CNR_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import cnr_pkg::*;

  localparam logic signed [31:0] THREE_Q = 32'(3) << FRAC_BITS;

  cnr_cfg_t cfg;

  cnr_state_e state_q, state_d;
  cnr_phase_e phase_q, phase_d;
  logic       use_prev_q, use_prev_d;
  logic [7:0] k_q, k_d;
  logic       done_q;

  logic signed [31:0] a3_q, a2_q, x_q, prev_q, l9_q, x2_q, t_q, u_q, s_q, f_q;
  logic signed [31:0] root_q;
  cnr_status_e        status_q;
  logic [7:0]         steps_q;

  cnr_alu_op_e        alu_op;
  logic signed [31:0] alu_a, alu_b, alu_res;
  logic signed [31:0] pt;

  logic               div_start, div_done;
  logic signed [31:0] div_quot;
  cnr_fin_t           fin;

  logic [31:0] s_abs, f_abs, floor_ext, tol_ext;
  logic        s_lt, s_le, s_zero, f_lt, f_le, limit_zero, k_at_limit;

  cnr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cnr_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  cnr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (f_q),
    .den_i   (s_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign pt = use_prev_q ? prev_q : x_q;

  assign s_abs      = abs32(s_q);
  assign f_abs      = abs32(f_q);
  assign floor_ext  = {1'b0, cfg.slope_floor};
  assign tol_ext    = {16'd0, cfg.tolerance};
  assign s_lt       = s_abs < floor_ext;
  assign s_le       = s_abs <= floor_ext;
  assign s_zero     = (s_q == 32'sd0);
  // start check is strict, in-loop check is not
  assign f_lt       = (f_abs < tol_ext) || (f_q == 32'sd0);
  assign f_le       = (f_abs <= tol_ext) || (f_q == 32'sd0);
  assign limit_zero = (cfg.iteration_limit == 8'd0);
  assign k_at_limit = (k_q == cfg.iteration_limit);

  // next state
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    use_prev_d = use_prev_q;
    k_d        = k_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d    = ST_L9;
          phase_d    = PH_START;
          use_prev_d = 1'b0;
          k_d        = 8'd0;
        end
      end
      ST_L9:   state_d = ST_SX2;
      ST_SX2:  state_d = (phase_q == PH_NEWF) ? ST_FX3 : ST_SQ;
      ST_SQ:   state_d = ST_S3;
      ST_S3:   state_d = ST_SS;
      ST_SS:   state_d = ST_SCHK;
      ST_SCHK: begin
        case (phase_q)
          PH_START: state_d = s_lt ? ST_IDLE : ST_FX3;
          PH_LOOP: begin
            if (s_le) begin
              // fall back to the slope at the previous point
              phase_d    = PH_PREV;
              use_prev_d = 1'b1;
              state_d    = ST_SX2;
            end else begin
              state_d = ST_DIV;
            end
          end
          default: state_d = s_zero ? ST_IDLE : ST_DIV;
        endcase
      end
      ST_FX3:  state_d = ST_FCUB;
      ST_FCUB: state_d = ST_FLIN;
      ST_FLIN: state_d = ST_F9;
      ST_F9:   state_d = ST_FSUB;
      ST_FSUB: state_d = ST_FADD;
      ST_FADD: state_d = ST_FCHK;
      ST_FCHK: begin
        if (phase_q == PH_START) begin
          if (f_lt || limit_zero) begin
            state_d = ST_IDLE;
          end else begin
            phase_d = PH_LOOP;
            state_d = ST_SX2;
          end
        end else begin
          if (f_le || k_at_limit) begin
            state_d = ST_IDLE;
          end else begin
            phase_d    = PH_LOOP;
            use_prev_d = 1'b0;
            state_d    = ST_SX2;
          end
        end
      end
      ST_DIV:  state_d = div_done ? ST_STEP : ST_DIV;
      ST_STEP: begin
        phase_d    = PH_NEWF;
        use_prev_d = 1'b0;
        k_d        = k_q + 8'd1;
        state_d    = ST_SX2;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    alu_op     = ALU_MUL;
    alu_a      = x_q;
    alu_b      = x_q;
    div_start  = 1'b0;
    fin.valid  = 1'b0;
    fin.status = STAT_LIMIT;
    case (state_q)
      ST_L9: begin
        alu_op = ALU_SCALE9;
        alu_a  = a2_q;
      end
      ST_SX2: begin
        alu_a = pt;
        alu_b = pt;
      end
      ST_SQ: begin
        alu_a = a3_q;
        alu_b = x2_q;
      end
      ST_S3: begin
        alu_op = ALU_SCALE3;
        alu_a  = t_q;
      end
      ST_SS: begin
        alu_op = ALU_SUB;
        alu_a  = t_q;
        alu_b  = l9_q;
      end
      ST_SCHK: begin
        case (phase_q)
          PH_START: begin
            if (s_lt) begin
              fin.valid  = 1'b1;
              fin.status = STAT_START_SLOPE;
            end
          end
          PH_LOOP: div_start = !s_le;
          default: begin
            if (s_zero) begin
              fin.valid  = 1'b1;
              fin.status = STAT_ZERO_SLOPE;
            end else begin
              div_start = 1'b1;
            end
          end
        endcase
      end
      ST_FX3: begin
        alu_a = x2_q;
        alu_b = x_q;
      end
      ST_FCUB: begin
        alu_a = a3_q;
        alu_b = t_q;
      end
      ST_FLIN: begin
        alu_a = a2_q;
        alu_b = x_q;
      end
      ST_F9: begin
        alu_op = ALU_SCALE9;
        alu_a  = u_q;
      end
      ST_FSUB: begin
        alu_op = ALU_SUB;
        alu_a  = t_q;
        alu_b  = u_q;
      end
      ST_FADD: begin
        alu_op = ALU_ADD;
        alu_a  = t_q;
        alu_b  = THREE_Q;
      end
      ST_FCHK: begin
        if (phase_q == PH_START) begin
          if (f_lt) begin
            fin.valid  = 1'b1;
            fin.status = STAT_CONVERGED;
          end else if (limit_zero) begin
            fin.valid  = 1'b1;
            fin.status = STAT_LIMIT;
          end
        end else begin
          if (f_le) begin
            fin.valid  = 1'b1;
            fin.status = STAT_CONVERGED;
          end else if (k_at_limit) begin
            fin.valid  = 1'b1;
            fin.status = STAT_LIMIT;
          end
        end
      end
      ST_STEP: begin
        alu_op = ALU_SUB;
        alu_a  = x_q;
        alu_b  = t_q;  // quotient f/s
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_START;
      use_prev_q <= 1'b0;
      k_q        <= 8'd0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      use_prev_q <= use_prev_d;
      k_q        <= k_d;
      done_q     <= fin.valid;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          a3_q   <= coef_cubic_i;
          a2_q   <= coef_linear_i;
          x_q    <= start_point_i;
          prev_q <= 32'sd0;
        end
      end
      ST_L9:   l9_q <= alu_res;
      ST_SX2:  x2_q <= alu_res;
      ST_SQ, ST_S3, ST_FX3, ST_FCUB, ST_FSUB: t_q <= alu_res;
      ST_SS:   s_q <= alu_res;
      ST_FLIN, ST_F9: u_q <= alu_res;
      ST_FADD: f_q <= alu_res;
      ST_DIV: begin
        if (div_done) begin
          t_q <= div_quot;
        end
      end
      ST_STEP: begin
        x_q    <= alu_res;
        prev_q <= x_q;
      end
      default: ;
    endcase
    if (fin.valid) begin
      root_q   <= x_q;
      status_q <= fin.status;
      steps_q  <= k_q;
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign root_o       = root_q;
  assign status_o     = status_q;
  assign steps_used_o = steps_q;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cubic Newton root finder core. Words go in
// through the start/busy command port from a queue of pending requests.
// Each accepted word is solved by a saturating fixed-point Newton model in
// the bench and compared with the done_o strobe outputs. APB writes and
// read-backs sweep tolerance, iteration limit and slope floor between phases.
// ----------------------------------------------------------------------------
module tb;
  import cnr_pkg::*;

  localparam int unsigned FRAC        = CNR_FRAC_BITS;
  localparam longint      Q_ONE       = 64'sd1 << FRAC;
  localparam longint      WORD_MAX    = 64'sd2147483647;
  localparam longint      WORD_MIN    = -64'sd2147483648;
  localparam logic [1:0]  REG_UNMAPPED = 2'd3;
  localparam int unsigned TIMEOUT_CYCLES = 4_000_000;
  localparam int unsigned TAIL_CYCLES    = 100;

  typedef struct {
    logic signed [31:0] a3;
    logic signed [31:0] a2;
    logic signed [31:0] x0;
  } root_req_t;

  typedef struct {
    logic signed [31:0] root;
    cnr_status_e        status;
    logic [7:0]         steps;
  } root_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic signed [31:0]    coef_cubic_i = '0;
  logic signed [31:0]    coef_linear_i = '0;
  logic signed [31:0]    start_point_i = '0;
  logic                  done_o;
  logic signed [31:0]    root_o;
  logic [1:0]            status_o;
  logic [7:0]            steps_used_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CNR_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  root_req_t   pending_reqs[$];
  root_res_t   expected_roots[$];
  root_req_t   cur_req;
  cnr_cfg_t    cfg_shadow;
  int unsigned idle_pct = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  cubic_newton_root_finder_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .coef_cubic_i (coef_cubic_i),
    .coef_linear_i(coef_linear_i),
    .start_point_i(start_point_i),
    .done_o       (done_o),
    .root_o       (root_o),
    .status_o     (status_o),
    .steps_used_o (steps_used_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---- fixed-point Newton model ----
  function automatic longint sat_q(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // arithmetic shift floors toward minus infinity
  function automatic longint mul_q(input longint a, input longint b);
    longint p;
    p = a * b;
    return sat_q(p >>> FRAC);
  endfunction

  function automatic longint div_q(input longint n, input longint d);
    return sat_q((n * Q_ONE) / d);
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint cubic_val(input longint a3, input longint a2, input longint x);
    longint x2, x3, cub, lin, acc;
    x2  = mul_q(x, x);
    x3  = mul_q(x2, x);
    cub = mul_q(a3, x3);
    lin = sat_q(9 * mul_q(a2, x));
    acc = sat_q(cub - lin);
    return sat_q(acc + 3 * Q_ONE);
  endfunction

  function automatic longint cubic_slope(input longint a3, input longint a2, input longint x);
    longint x2, q;
    x2 = mul_q(x, x);
    q  = sat_q(3 * mul_q(a3, x2));
    return sat_q(q - sat_q(9 * a2));
  endfunction

  function automatic root_res_t solve_newton(input root_req_t req);
    root_res_t   r;
    longint      a3, a2, x, prev, f, s, nx, tol, flr;
    int unsigned k;
    logic        running;
    a3   = req.a3;
    a2   = req.a2;
    x    = req.x0;
    prev = 0;
    tol  = longint'(cfg_shadow.tolerance);
    flr  = longint'(cfg_shadow.slope_floor);
    r.status = STAT_LIMIT;
    r.steps  = '0;
    if (mag(cubic_slope(a3, a2, x)) < flr) begin
      r.status = STAT_START_SLOPE;
    end else begin
      f = cubic_val(a3, a2, x);
      if (mag(f) < tol || f == 0) begin
        r.status = STAT_CONVERGED;
      end else begin
        k = 0;
        running = 1'b1;
        while (running && k < cfg_shadow.iteration_limit) begin
          s = cubic_slope(a3, a2, x);
          // flat spot: fall back to the slope at the previous iterate
          if (mag(s) <= flr) s = cubic_slope(a3, a2, prev);
          if (s == 0) begin
            r.status = STAT_ZERO_SLOPE;
            r.steps  = k[7:0];
            running  = 1'b0;
          end else begin
            nx   = sat_q(x - div_q(f, s));
            prev = x;
            x    = nx;
            f    = cubic_val(a3, a2, x);
            k++;
            r.steps = k[7:0];
            if (mag(f) <= tol || f == 0) begin
              r.status = STAT_CONVERGED;
              running  = 1'b0;
            end
          end
        end
      end
    end
    r.root = x[31:0];
    return r;
  endfunction

  // ---- checking ----
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // ---- driver: one request word per start/busy handshake ----
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) expected_roots.push_back(solve_newton(cur_req));
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur_req = pending_reqs.pop_front();
        start         <= 1'b1;
        coef_cubic_i  <= cur_req.a3;
        coef_linear_i <= cur_req.a2;
        start_point_i <= cur_req.x0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---- monitor: result word is valid only in the done_o cycle ----
  always @(posedge clk_i) begin
    root_res_t exp_res;
    if (rst_ni && done_o) begin
      if (expected_roots.size() == 0) begin
        report_mismatch($sformatf("unexpected result root=%0d status=%0d steps=%0d",
                                  root_o, status_o, steps_used_o));
      end else begin
        exp_res = expected_roots.pop_front();
        if (root_o !== exp_res.root)
          report_mismatch($sformatf("root got %0d exp %0d", root_o, exp_res.root));
        if (status_o !== exp_res.status)
          report_mismatch($sformatf("status got %0d exp %0d", status_o, exp_res.status));
        if (steps_used_o !== exp_res.steps)
          report_mismatch($sformatf("steps got %0d exp %0d", steps_used_o, exp_res.steps));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---- APB access and register shadow ----
  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] unused;
    apb_access(1'b1, idx, data, unused);
    case (idx)
      CNR_REG_TOLERANCE:   cfg_shadow.tolerance       = data[15:0];
      CNR_REG_ITER_LIMIT:  cfg_shadow.iteration_limit = data[7:0];
      CNR_REG_SLOPE_FLOOR: cfg_shadow.slope_floor     = data[30:0];
      default: ; // unmapped address, write dropped
    endcase
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] exp_val);
    logic [31:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== exp_val)
      report_mismatch($sformatf("reg %0d read %h exp %h", idx, got, exp_val));
  endtask

  task automatic readback_cfg();
    check_reg(CNR_REG_TOLERANCE,   {16'd0, cfg_shadow.tolerance});
    check_reg(CNR_REG_ITER_LIMIT,  {24'd0, cfg_shadow.iteration_limit});
    check_reg(CNR_REG_SLOPE_FLOOR, {1'b0, cfg_shadow.slope_floor});
  endtask

  task automatic set_cfg(input int unsigned tol, input int unsigned lim, input int unsigned flr);
    write_reg(CNR_REG_TOLERANCE, tol);
    write_reg(CNR_REG_ITER_LIMIT, lim);
    write_reg(CNR_REG_SLOPE_FLOOR, flr);
    readback_cfg();
  endtask

  // ---- stimulus ----
  task automatic queue_req(input longint a3, input longint a2, input longint x0);
    root_req_t req;
    req.a3 = a3[31:0];
    req.a2 = a2[31:0];
    req.x0 = x0[31:0];
    pending_reqs.push_back(req);
  endtask

  function automatic longint spread(input int unsigned half);
    return longint'($urandom_range(2 * half)) - longint'(half);
  endfunction

  // mostly small, well-behaved cubics; some mid-range and raw 32-bit noise
  task automatic queue_random(input int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 60)
        queue_req(spread(4 << FRAC), spread(2 << FRAC), spread(8 << FRAC));
      else if (pick < 80)
        queue_req(spread(1 << 24), spread(1 << 24), spread(1 << 24));
      else
        queue_req(longint'($signed($urandom)), longint'($signed($urandom)),
                  longint'($signed($urandom)));
    end
  endtask

  // all words in and all results back, block idle
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || start || expected_roots.size() != 0 || busy)
      @(negedge clk_i);
  endtask

  initial begin
    cfg_shadow.tolerance       = CNR_TOLERANCE_RST;
    cfg_shadow.iteration_limit = CNR_ITER_LIMIT_RST;
    cfg_shadow.slope_floor     = CNR_SLOPE_FLOOR_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    readback_cfg();

    // reset settings, directed corners
    @(negedge clk_i);
    idle_pct = 0;
    queue_req(0, 0, 0);                         // start slope too small
    queue_req(WORD_MAX, WORD_MAX, WORD_MAX);
    queue_req(WORD_MIN, WORD_MIN, WORD_MIN);
    queue_req(WORD_MAX, WORD_MIN, 0);
    queue_req(WORD_MIN, WORD_MAX, WORD_MAX);
    queue_req(0, WORD_MAX, WORD_MIN);
    queue_req(Q_ONE, Q_ONE, 0);                 // x^3 - 9x + 3
    queue_req(Q_ONE, Q_ONE, 3 * Q_ONE);
    queue_req(Q_ONE, Q_ONE, -4 * Q_ONE);
    queue_req(-3 * Q_ONE, 0, Q_ONE);            // f(x0) exactly zero
    queue_req(-3 * Q_ONE + 40, 0, Q_ONE);       // f(x0) inside tolerance
    queue_req(-3 * Q_ONE + 66, 0, Q_ONE);       // f(x0) on the tolerance edge
    queue_req(98304, 21845, 0);                 // oscillates between two points, hits limit
    queue_req(Q_ONE, -Q_ONE, Q_ONE);
    queue_req(-1, 1, -1);
    queue_req(Q_ONE, 0, 0);                     // zero slope at x0
    queue_req(0, Q_ONE, 5 * Q_ONE);             // linear, one step
    queue_random(20);
    wait_drained();

    // floor 0: flat start passes, then no usable slope anywhere
    set_cfg(1, 1, 0);
    @(negedge clk_i);
    idle_pct = 45;
    queue_req(0, 0, 0);
    queue_req(0, 0, Q_ONE);
    queue_random(40);
    wait_drained();

    set_cfg(65535, 255, 32'h7fffffff);
    @(negedge clk_i);
    idle_pct = 26;
    queue_random(12);
    wait_drained();

    // no steps allowed
    set_cfg(66, 0, 655);
    @(negedge clk_i);
    idle_pct = 0;
    queue_req(Q_ONE, Q_ONE, 0);
    queue_random(15);
    wait_drained();

    set_cfg($urandom_range(65535, 1), $urandom_range(30, 1), $urandom_range(5000, 0));
    @(negedge clk_i);
    idle_pct = 26;
    queue_random(60);
    wait_drained();

    set_cfg(500, 255, 0);
    @(negedge clk_i);
    idle_pct = 45;
    queue_random(8);
    wait_drained();

    // |slope| equal to floor: start passes, step falls back to prev slope
    set_cfg(66, 20, 589824);
    @(negedge clk_i);
    queue_req(0, Q_ONE, 7 * Q_ONE);
    queue_random(40);
    wait_drained();

    set_cfg($urandom_range(65535, 1), $urandom_range(50, 2), $urandom_range(1 << 20, 0));
    write_reg(REG_UNMAPPED, $urandom);
    readback_cfg();
    @(negedge clk_i);
    idle_pct = 0;
    queue_random(70);
    wait_drained();

    set_cfg(CNR_TOLERANCE_RST, CNR_ITER_LIMIT_RST, CNR_SLOPE_FLOOR_RST);
    @(negedge clk_i);
    idle_pct = 26;
    queue_random(30);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
